// ===== src/b64c_pkg.sv =====
`timescale 1ns / 1ps

package b64c_pkg;

    // Pad character and the special alphabet characters.
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LENGTH  = 2'd2
    } t_status;

    // Group state carried from one item to the next.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  fill;
        logic        third_pad;
        logic        quad_inv;
    } t_group;

    // Up to four result bytes caused by one item.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
        t_status         status;
    } t_burst;

    // Decoded sextet with a flag for membership in the alphabet.
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // Sextet value to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] w;
        w = {2'b00, s};
        if (s < 6'd26) begin
            return CHAR_UP_A + w;
        end else if (s < 6'd52) begin
            return CHAR_LO_A + w - 8'd26;
        end else if (s < 6'd62) begin
            return CHAR_ZERO + w - 8'd52;
        end else if (s == 6'd62) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

    // Alphabet character to sextet value; ok is low outside the alphabet.
    function automatic t_sextet dec_sextet(input logic [7:0] c);
        t_sextet r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r.val = 6'(c - CHAR_UP_A);
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            r.val = 6'(c - CHAR_LO_A + 8'd26);
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r.val = 6'(c - CHAR_ZERO + 8'd52);
        end else if (c == CHAR_PLUS) begin
            r.val = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/b64c_core.sv =====
`timescale 1ns / 1ps

module b64c_core
    import b64c_pkg::*;
(
    input  logic       i_mode,
    input  t_group     i_grp,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output t_group     o_grp,
    output t_burst     o_burst
);

    logic [23:0] bits_e;
    logic [23:0] bits_a;
    logic [1:0]  fill_e;
    logic [23:0] bits_d;
    t_sextet     sx;
    logic        is_pad;
    logic        inv_d;
    logic [5:0]  v;
    logic [1:0]  drop;

    always_comb begin
        // Encode path: shift in the byte, left-align a partial group.
        bits_e = {i_grp.bits[15:0], i_data};
        fill_e = i_grp.fill + 2'd1;
        case (fill_e)
            2'd1:    bits_a = {bits_e[7:0], 16'h0000};
            2'd2:    bits_a = {bits_e[15:0], 8'h00};
            default: bits_a = bits_e;
        endcase

        // Decode path: pad and invalid characters count as sextet zero.
        sx     = dec_sextet(i_data);
        is_pad = (i_data == PAD_CHAR);
        v      = sx.ok ? sx.val : 6'd0;
        inv_d  = i_grp.quad_inv | (!sx.ok && !is_pad);
        bits_d = {i_grp.bits[17:0], v};
        drop   = i_last ? ({1'b0, is_pad} + {1'b0, i_grp.third_pad}) : 2'd0;

        o_grp   = i_grp;
        o_burst = '0;

        if (!i_mode) begin
            o_grp.bits = bits_e;
            o_grp.fill = fill_e;
            if (fill_e == 2'd3 || i_last) begin
                o_burst.bytes[0] = enc_char(bits_a[23:18]);
                o_burst.bytes[1] = enc_char(bits_a[17:12]);
                o_burst.bytes[2] = (fill_e >= 2'd2) ? enc_char(bits_a[11:6]) : PAD_CHAR;
                o_burst.bytes[3] = (fill_e == 2'd3) ? enc_char(bits_a[5:0]) : PAD_CHAR;
                o_burst.count    = 3'd4;
                o_burst.last     = i_last;
                o_burst.status   = ST_OK;
                o_grp            = '0;
            end
        end else if (i_grp.fill != 2'd3) begin
            // Quad still filling.
            o_grp.bits     = bits_d;
            o_grp.fill     = fill_e;
            o_grp.quad_inv = inv_d;
            if (i_grp.fill == 2'd2) begin
                o_grp.third_pad = is_pad;
            end
            if (i_last) begin
                // Stream ended inside a quad: one length error word.
                o_burst.count  = 3'd1;
                o_burst.last   = 1'b1;
                o_burst.status = ST_LENGTH;
                o_grp          = '0;
            end
        end else begin
            // Quad complete: up to three bytes, trailing pads drop bytes.
            o_burst.bytes[0] = bits_d[23:16];
            o_burst.bytes[1] = bits_d[15:8];
            o_burst.bytes[2] = bits_d[7:0];
            o_burst.count    = 3'd3 - {1'b0, drop};
            o_burst.last     = i_last;
            o_burst.status   = inv_d ? ST_INVALID : ST_OK;
            o_grp            = '0;
        end
    end

endmodule

// ===== src/b64c_out_buf.sv =====
`timescale 1ns / 1ps

module b64c_out_buf
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last,
    output logic [1:0] o_status
);

    t_burst     r_burst;
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    logic       at_end;
    logic       take;

    // The word on the port and whether it is the last of the burst.
    assign at_end   = ({1'b0, r_idx} + 3'd1) == r_cnt;
    assign take     = o_valid && i_ready;
    assign o_valid  = (r_cnt != 3'd0);
    assign o_data   = r_burst.bytes[r_idx];
    assign o_last   = r_burst.last && at_end;
    assign o_status = r_burst.status;
    assign o_free   = !o_valid || (at_end && i_ready);

    // Burst count and read index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
            r_idx <= 2'd0;
        end else if (take) begin
            if (at_end) begin
                r_cnt <= 3'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Burst payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule

// ===== src/base64_codec_unit.sv =====
// Base64 codec (standard alphabet), one byte per stream word in and out. Write the
// mode register first: 0 encodes raw bytes to characters, 1 decodes characters to
// bytes; a write also clears any partial group. Mark the final input word with
// tlast: encode then zero-fills and pads the last group with '=', decode drops bytes
// for trailing '=' in the final quad, and a decode stream that ends inside a quad
// gives one word with data 0 and status 2. Status 1 flags a quad that held a
// character outside the alphabet. A result passes through the input register and the
// output buffer register. Decode takes one character per cycle while the output is
// ready; encode input is limited by the output buffer, which sends one character of a
// four-character group per cycle while the output is ready.
`timescale 1ns / 1ps

module base64_codec_unit
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Mode register write.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // Input stream.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_in
    input  logic       s_axis_tlast,
    // Output stream.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_out
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    logic       r_mode;
    t_group     r_grp;
    t_group     n_grp;
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    t_burst     burst;
    logic       buf_free;
    logic       consume;
    logic       cfg_wr;

    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign consume       = r_in_valid && (burst.count == 3'd0 || buf_free);
    assign s_axis_tready = !r_in_valid || consume;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Mode register and group state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_grp  <= '0;
        end else if (cfg_wr) begin
            r_mode <= i_cfg_data;
            r_grp  <= '0;
        end else if (consume) begin
            r_grp <= n_grp;
        end
    end

    b64c_core u_core (
        .i_mode  (r_mode),
        .i_grp   (r_grp),
        .i_data  (r_in_data),
        .i_last  (r_in_last),
        .o_grp   (n_grp),
        .o_burst (burst)
    );

    b64c_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (consume && burst.count != 3'd0),
        .i_burst  (burst),
        .o_free   (buf_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_status (m_axis_tuser)
    );

endmodule

// ===== src/b64c_checker.sv =====
`timescale 1ns / 1ps

module b64c_checker
    import b64c_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       i_cfg_data,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    logic r_mode;

    // Track the mode as written on the register port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // A stalled output word stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    // A stalled output word keeps its contents.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Encoded characters always carry status ok.
    a_enc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_mode |-> m_axis_tuser == ST_OK)
        else $error("encode word with nonzero status");

    // A length error is a lone zero word that ends the stream.
    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_LENGTH |->
            m_axis_tlast && m_axis_tdata == 8'h00 && r_mode)
        else $error("malformed length error word");

    // No status code beyond the defined ones.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined status code");

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import b64c_pkg::*;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 50;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_out_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    base64_codec_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Words waiting to be sent and codec words expected back.
    t_in_word  pending_words[$];
    t_out_word expected_words[$];

    // Predicted codec state.
    logic        codec_mode;
    logic [23:0] grp_bits;
    logic [1:0]  grp_fill;
    logic        grp_third_pad;
    logic        grp_invalid;

    int  error_count;
    int  quiet_cycles;
    int  queued_words;
    bit  in_taken;
    int  src_gap_pct;
    int  src_idle_left;
    int  snk_stall_pct;
    int  snk_idle_left;
    int  hold_requests;
    int  holds_served;
    int  hold_left;

    function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
        return B64_ALPHABET[8 * (63 - idx) +: 8];
    endfunction

    // Position of a character in the alphabet, or 64 when it is not there.
    function automatic logic [6:0] alphabet_index(input logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (alphabet_char(6'(k)) == c) begin
                return 7'(k);
            end
        end
        return 7'd64;
    endfunction

    function automatic void clear_group();
        grp_bits      = '0;
        grp_fill      = '0;
        grp_third_pad = 1'b0;
        grp_invalid   = 1'b0;
    endfunction

    function automatic void push_expected(input logic [7:0] d, input logic l, input t_status st);
        t_out_word w;
        w.data   = d;
        w.last   = l;
        w.status = st;
        expected_words.push_back(w);
    endfunction

    // Works out the codec words caused by one accepted input word.
    function automatic void predict_codec(input logic [7:0] d, input logic l);
        logic [23:0] shifted;
        logic [7:0]  ch;
        logic [6:0]  sx;
        logic        is_pad;
        int          n;
        int          count;
        t_status     st;
        if (codec_mode == MODE_ENCODE) begin
            grp_bits = {grp_bits[15:0], d};
            grp_fill = grp_fill + 2'd1;
            if (grp_fill == 2'd3 || l) begin
                n = int'(grp_fill);
                shifted = grp_bits << (8 * (3 - n));
                for (int k = 0; k < 4; k++) begin
                    ch = (k <= n) ? alphabet_char(shifted[23 - 6 * k -: 6]) : PAD_CHAR;
                    push_expected(ch, l && k == 3, ST_OK);
                end
                clear_group();
            end
        end else begin
            is_pad = (d == PAD_CHAR);
            sx = alphabet_index(d);
            if (is_pad) begin
                sx = 7'd0;
            end else if (sx == 7'd64) begin
                sx = 7'd0;
                grp_invalid = 1'b1;
            end
            if (grp_fill < 2'd3) begin
                if (grp_fill == 2'd2) begin
                    grp_third_pad = is_pad;
                end
                grp_bits = {grp_bits[17:0], sx[5:0]};
                grp_fill = grp_fill + 2'd1;
                // A stream that ends inside a quad gives one length error word.
                if (l) begin
                    push_expected(8'h00, 1'b1, ST_LENGTH);
                    clear_group();
                end
            end else begin
                grp_bits = {grp_bits[17:0], sx[5:0]};
                count = 3;
                if (l) begin
                    count = 3 - int'(is_pad) - int'(grp_third_pad);
                end
                st = grp_invalid ? ST_INVALID : ST_OK;
                for (int k = 0; k < count; k++) begin
                    push_expected(grp_bits[23 - 8 * k -: 8], l && (k + 1 == count), st);
                end
                clear_group();
            end
        end
    endfunction

    // Clock and reset.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Input driver: presents the next pending word once the current one is taken.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (src_idle_left > 0) begin
                src_idle_left = src_idle_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_words[0].data;
                s_axis_tlast  <= pending_words[0].last;
                void'(pending_words.pop_front());
                if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) begin
                    src_idle_left = $urandom_range(19, 1);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output receiver: random stall bursts, and long hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_served < hold_requests) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (snk_idle_left > 0) begin
            snk_idle_left = snk_idle_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct) begin
                snk_idle_left = $urandom_range(19, 1);
            end
        end
    end

    // Monitor: predicts on every accepted input word and checks every output word.
    always @(posedge i_clk) begin
        t_out_word want;
        bit        any_taken;
        in_taken  = s_axis_tvalid && s_axis_tready;
        any_taken = in_taken;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                codec_mode = i_cfg_data;
                clear_group();
                any_taken = 1'b1;
            end
            if (in_taken) begin
                predict_codec(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                any_taken = 1'b1;
                if (expected_words.size() == 0) begin
                    $error("unexpected word: data %0h last %0b status %0d",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        $error("data_out: expected %0h, got %0h", want.data, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_out: expected %0b, got %0b", want.last, m_axis_tlast);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            // Watchdog on cycles in which no word moves anywhere.
            quiet_cycles = any_taken ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [7:0] d, input logic l);
        t_in_word w;
        w.data = d;
        w.last = l;
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic push_text(input string s, input bit ends);
        for (int k = 0; k < s.len(); k++) begin
            push_word(s[k], ends && (k == s.len() - 1));
        end
    endtask

    // Waits until every word is sent and answered, then lets the pipeline settle.
    task automatic wait_idle(input int settle);
        do @(posedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_encode_stream();
        int len;
        len = $urandom_range(12, 1);
        for (int k = 0; k < len; k++) begin
            push_word(8'($urandom_range(255)), k == len - 1);
        end
    endtask

    // Mostly well-formed base64 text, with stray bytes and cut-short streams mixed in.
    task automatic add_decode_stream();
        int         nquads;
        int         pads;
        int         len;
        bit         cut;
        logic [7:0] c;
        nquads = $urandom_range(3, 1);
        pads   = $urandom_range(2, 0);
        cut    = ($urandom_range(9) == 0);
        len    = 4 * nquads;
        if (cut) begin
            len = len - $urandom_range(3, 1);
        end
        for (int k = 0; k < len; k++) begin
            c = alphabet_char(6'($urandom_range(63)));
            if (!cut && k >= 4 * nquads - pads) begin
                c = PAD_CHAR;
            end
            if ($urandom_range(19) == 0) begin
                c = 8'($urandom_range(255));
            end
            push_word(c, k == len - 1);
        end
    endtask

    // Stimulus sequence.
    initial begin
        logic phase_mode;
        int   start_count;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        codec_mode    = MODE_ENCODE;
        clear_group();
        error_count   = 0;
        quiet_cycles  = 0;
        queued_words  = 0;
        src_gap_pct   = 20;
        snk_stall_pct = 20;
        src_idle_left = 0;
        snk_idle_left = 0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Encode: one, two and three byte streams, extreme byte values.
        write_mode(MODE_ENCODE);
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h80, 1'b1);
        wait_idle(SETTLE_CYCLES);

        // A partial quad is dropped by the next mode write.
        write_mode(MODE_DECODE);
        push_text("QU", 1'b0);
        wait_idle(SETTLE_CYCLES);
        write_mode(MODE_DECODE);

        // Decode: pads inside the stream, final-quad padding, a stray character,
        // third-place pad only, and a stream that ends inside a quad.
        push_text("A=B=", 1'b0);
        push_text("QQ==", 1'b1);
        push_text("Z#9/", 1'b1);
        push_text("AB=C", 1'b1);
        push_text("TWFu", 1'b0);
        push_text("ab", 1'b1);
        wait_idle(SETTLE_CYCLES);

        // Random phases, alternating mode; phase 1 and the last two run without idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            phase_mode = (p % 2 == 0) ? MODE_ENCODE : MODE_DECODE;
            write_mode(phase_mode);
            if (p == 1 || p >= NUM_PHASES - 2) begin
                src_gap_pct   = 0;
                snk_stall_pct = 0;
            end else begin
                src_gap_pct   = $urandom_range(35, 5);
                snk_stall_pct = $urandom_range(35, 5);
            end
            start_count = queued_words;
            while (queued_words - start_count < PHASE_WORDS) begin
                if (phase_mode == MODE_ENCODE) begin
                    add_encode_stream();
                end else begin
                    add_decode_stream();
                end
            end
            // Back-pressure: the receiver stops long enough for the input to stall.
            if (p == 2 || p == 5) begin
                hold_requests++;
            end
            wait_idle(SETTLE_CYCLES);
        end

        wait_idle(DRAIN_CYCLES);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
